// ===== design/gsp_pkg.sv =====
// Package for the game-pad serial poller: frame size, command bytes,
// register map and word widths. No dependencies.
`default_nettype none

package gsp_pkg;

    // Bytes exchanged in one poll frame
    localparam int unsigned FRAME_BYTES = 9;
    localparam int unsigned BYTE_IDX_W  = 4;

    // Command and reply bytes
    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_POLL  = 8'h42;
    localparam logic [7:0] CMD_IDLE  = 8'h00;
    localparam logic [7:0] ID_READY  = 8'h5A;

    // Timing registers
    localparam int unsigned TICK_W         = 10;
    localparam logic [9:0]  HALF_BIT_RESET = 10'd16;
    localparam logic [9:0]  GAP_RESET      = 10'd16;

    // Register indexes (paddr[2])
    localparam logic REG_HALF_BIT = 1'b0;
    localparam logic REG_GAP      = 1'b1;

    // Word widths
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 64;

    // Command byte sent in frame position idx
    function automatic logic [7:0] command_byte(input logic [BYTE_IDX_W-1:0] idx);
        logic [7:0] cmd;
        cmd = CMD_IDLE;
        if (idx == 4'd0) begin
            cmd = CMD_START;
        end else if (idx == 4'd1) begin
            cmd = CMD_POLL;
        end
        return cmd;
    endfunction

endpackage

`default_nettype wire

// ===== design/gamepad_serial_poller_core.sv =====
// Game-pad serial poller: tick-driven pin sequencer, frame capture and
// held results, with an APB register port. Depends on gsp_pkg.
//
// A result word is registered and appears in the cycle after its input word is taken.
// Throughput: one word per cycle while the sink keeps up; the sequencer state is updated in a single
// pass per word and the result register frees as soon as the sink takes it.
// Reset: aresetn is synchronous, active low; sequencer idles, held results
// clear and both timing registers return to 16.
`default_nettype none

module gamepad_serial_poller_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Tick input: [0] poll_request, [1] data_in, [7:2] zero
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [gsp_pkg::S_DATA_W-1:0] s_tdata,
    // Result: [0] select_n, [1] serial_clock, [2] data_out, [3] busy_res,
    // [4] done_res, [5] connected, [13:6] mode, [29:14] buttons,
    // [37:30] right_x, [45:38] right_y, [53:46] left_x, [61:54] left_y, [63:62] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [gsp_pkg::M_DATA_W-1:0] m_tdata
);

    import gsp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_GAP1 = 3'd1,
        PH_HIGH = 3'd2,
        PH_LOW  = 3'd3,
        PH_GAP2 = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    // Configuration registers
    logic [TICK_W-1:0] half_bit_reg;
    logic [TICK_W-1:0] gap_reg;
    logic              cfg_write;

    // Sequencer state
    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [2:0]            bit_reg, bit_next;
    logic [BYTE_IDX_W-1:0] byte_reg, byte_next;
    logic [7:0]            tx_reg, tx_next;
    logic [7:0]            rx_reg, rx_next;

    // Captured frame bytes (no reset: all written before use)
    logic [7:0]            frame_mem [FRAME_BYTES];
    logic                  store_en;
    logic [7:0]            store_data;

    // Held results
    logic [15:0] buttons_reg, buttons_next;
    logic [7:0]  right_x_reg, right_x_next;
    logic [7:0]  right_y_reg, right_y_next;
    logic [7:0]  left_x_reg, left_x_next;
    logic [7:0]  left_y_reg, left_y_next;
    logic [7:0]  mode_reg, mode_next;
    logic        connected_reg, connected_next;

    // Output register
    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;
    logic [63:0]       m_tdata_next;

    logic              s_accept;
    logic              poll_request;
    logic              data_in;
    logic              sel_n, sclk, dout, busy, done;
    logic [TICK_W-1:0] half_len;
    logic [TICK_W-1:0] tick_inc;

    assign poll_request = s_tdata[0];
    assign data_in      = s_tdata[1];

    // Take a new word whenever the result register is empty or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // APB register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            REG_HALF_BIT: prdata = {22'd0, half_bit_reg};
            REG_GAP:      prdata = {22'd0, gap_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_bit_reg <= HALF_BIT_RESET;
            gap_reg      <= GAP_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_HALF_BIT: half_bit_reg <= pwdata[TICK_W-1:0];
                REG_GAP:      gap_reg      <= pwdata[TICK_W-1:0];
                default:      ;
            endcase
        end
    end

    // A zero half bit counts as one tick
    assign half_len = (half_bit_reg == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : half_bit_reg;

    // Advance the sequencer by one tick
    always_comb begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        tx_next        = tx_reg;
        rx_next        = rx_reg;
        buttons_next   = buttons_reg;
        right_x_next   = right_x_reg;
        right_y_next   = right_y_reg;
        left_x_next    = left_x_reg;
        left_y_next    = left_y_reg;
        mode_next      = mode_reg;
        connected_next = connected_reg;
        store_en       = 1'b0;
        store_data     = rx_reg;
        sel_n          = 1'b1;
        sclk           = 1'b1;
        dout           = 1'b0;
        busy           = 1'b0;
        done           = 1'b0;

        // start a poll on an idle tick
        if (phase_reg == PH_IDLE && poll_request) begin
            phase_next = PH_GAP1;
            tick_next  = '0;
            bit_next   = '0;
            byte_next  = '0;
            rx_next    = '0;
            tx_next    = command_byte('0);
        end
        // skip the gap when it is zero
        if (phase_next == PH_GAP1 && gap_reg == '0) begin
            phase_next = PH_HIGH;
            tick_next  = '0;
        end

        tick_inc = tick_next + {{(TICK_W-1){1'b0}}, 1'b1};

        unique case (phase_next)
            PH_IDLE: begin
                tick_next = tick_next;
            end
            PH_GAP1: begin
                sel_n     = 1'b0;
                busy      = 1'b1;
                tick_next = tick_inc;
                if (tick_inc >= gap_reg) begin
                    phase_next = PH_HIGH;
                    tick_next  = '0;
                end
            end
            PH_HIGH: begin
                sel_n     = 1'b0;
                busy      = 1'b1;
                dout      = tx_next[0];
                tick_next = tick_inc;
                if (tick_inc >= half_len) begin
                    phase_next = PH_LOW;
                    tick_next  = '0;
                end
            end
            PH_LOW: begin
                sel_n = 1'b0;
                sclk  = 1'b0;
                busy  = 1'b1;
                dout  = tx_next[0];
                // sample data on the first low tick
                if (tick_next == '0) begin
                    rx_next = rx_next | (8'(data_in) << bit_next);
                end
                tick_next = tick_inc;
                if (tick_inc >= half_len) begin
                    tick_next = '0;
                    tx_next   = tx_next >> 1;
                    if (bit_next == 3'd7) begin
                        bit_next   = '0;
                        store_en   = (byte_next < BYTE_IDX_W'(FRAME_BYTES));
                        store_data = rx_next;
                        rx_next    = '0;
                        byte_next  = byte_next + 1'b1;
                        if (byte_next >= BYTE_IDX_W'(FRAME_BYTES)) begin
                            phase_next = (gap_reg == '0) ? PH_DONE : PH_GAP2;
                        end else begin
                            tx_next    = command_byte(byte_next);
                            phase_next = PH_HIGH;
                        end
                    end else begin
                        bit_next   = bit_next + 1'b1;
                        phase_next = PH_HIGH;
                    end
                end
            end
            PH_GAP2: begin
                busy      = 1'b1;
                tick_next = tick_inc;
                if (tick_inc >= gap_reg) begin
                    phase_next = PH_DONE;
                    tick_next  = '0;
                end
            end
            PH_DONE: begin
                done         = 1'b1;
                buttons_next = {frame_mem[4], frame_mem[3]};
                right_x_next = frame_mem[5];
                right_y_next = frame_mem[6];
                left_x_next  = frame_mem[7];
                left_y_next  = frame_mem[8];
                if (frame_mem[2] == ID_READY) begin
                    mode_next      = frame_mem[1];
                    connected_next = 1'b1;
                end else begin
                    mode_next      = 8'd0;
                    connected_next = 1'b0;
                end
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase

        m_tdata_next = {2'b00, left_y_next, left_x_next, right_y_next, right_x_next,
                        buttons_next, mode_next, connected_next,
                        done, busy, dout, sclk, sel_n};
    end

    // Hold state, held results and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            byte_reg      <= '0;
            tx_reg        <= '0;
            rx_reg        <= '0;
            buttons_reg   <= '0;
            right_x_reg   <= '0;
            right_y_reg   <= '0;
            left_x_reg    <= '0;
            left_y_reg    <= '0;
            mode_reg      <= '0;
            connected_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end else begin
            if (s_accept) begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                bit_reg       <= bit_next;
                byte_reg      <= byte_next;
                tx_reg        <= tx_next;
                rx_reg        <= rx_next;
                buttons_reg   <= buttons_next;
                right_x_reg   <= right_x_next;
                right_y_reg   <= right_y_next;
                left_x_reg    <= left_x_next;
                left_y_reg    <= left_y_next;
                mode_reg      <= mode_next;
                connected_reg <= connected_next;
                m_tvalid_reg  <= 1'b1;
                m_tdata_reg   <= m_tdata_next;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    // Store each received byte at its frame position
    always_ff @(posedge aclk) begin
        if (s_accept && store_en) begin
            frame_mem[byte_reg] <= store_data;
        end
    end

    // Byte position never runs past the frame end
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_reg <= BYTE_IDX_W'(FRAME_BYTES))
        else $error("byte position beyond frame");

    // Sequencer holds while no tick is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> ($stable(phase_reg) && $stable(tick_reg) && $stable(byte_reg)))
        else $error("sequencer moved without a tick");

    // A done tick yields a done word with select high and busy low
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg == PH_DONE) |=>
            (m_tvalid_reg && m_tdata_reg[4] && !m_tdata_reg[3] && m_tdata_reg[0]))
        else $error("done tick not reported");

    // An idle tick without request stays idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg == PH_IDLE && !s_tdata[0]) |=> (phase_reg == PH_IDLE))
        else $error("poll started without request");

    // Clock is low only in the low half of a bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !sclk) |-> (phase_next == PH_LOW || phase_next == PH_HIGH
                                 || phase_reg == PH_LOW))
        else $error("serial clock low outside a bit");

endmodule

`default_nettype wire
